@@ rtl/core/fnss_pkg.sv @@
`default_nettype none

package fnss_pkg;

   localparam int ROW_WIDTH_BITS = 11;
   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register index, taken from paddr[2]
   localparam logic REG_ROW_WIDTH = 1'b0;

   typedef struct packed {
      logic last;
      logic frame_end;
      logic emit;
      logic zero_top;
      logic has_left;
      logic has_right;
   } fnss_flags_type;

endpackage

`default_nettype wire

@@ rtl/core/fnss_ram.sv @@
`default_nettype none

module fnss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/fnss_seq.sv @@
`default_nettype none

module fnss_seq import fnss_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [ROW_WIDTH_BITS-1:0]    row_width,
   input  wire logic                         take,
   input  wire logic                         mode,
   input  wire logic [SAMPLE_BITS-1:0]       sample,
   output logic                              op_valid,
   output logic [$clog2(MAX_WIDTH)-1:0]      op_col,
   output logic [SAMPLE_BITS-1:0]            op_bottom,
   output fnss_flags_type                    op_flags
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int WCW    = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_BITS) ?
                           $clog2(MAX_WIDTH + 1) : ROW_WIDTH_BITS;

   localparam logic [1:0] RS_FIRST = 2'd0;
   localparam logic [1:0] RS_BODY  = 2'd1;
   localparam logic [1:0] RS_FLUSH = 2'd2;

   logic [ADDR_W-1:0] col_ff, col_in;
   logic [1:0]        rows_ff, rows_in;

   logic [WCW-1:0]    rw_ext;
   logic [WCW-1:0]    eff_w;
   logic [WCW-1:0]    wm1;
   logic [ADDR_W-1:0] last_col;
   logic [ADDR_W-1:0] c;
   logic              last;
   logic              active;

   always_comb begin
      rw_ext = WCW'(row_width);
      if (rw_ext == '0) begin
         eff_w = WCW'(1);
      end else if (rw_ext > WCW'(MAX_WIDTH)) begin
         eff_w = WCW'(MAX_WIDTH);
      end else begin
         eff_w = rw_ext;
      end
      wm1      = eff_w - WCW'(1);
      last_col = wm1[ADDR_W-1:0];
      c        = (WCW'(col_ff) >= eff_w) ? last_col : col_ff;
      last     = (c == last_col);
   end

   always_comb begin
      if (!mode) begin
         active = (rows_ff != RS_FLUSH);
      end else begin
         active = (rows_ff != RS_FIRST) && !((rows_ff == RS_BODY) && (col_ff != '0));
      end
   end

   always_comb begin
      col_in  = col_ff;
      rows_in = rows_ff;
      if (take && active) begin
         if (last) begin
            col_in = '0;
            unique case (rows_ff)
               RS_FIRST: rows_in = RS_BODY;
               RS_BODY:  rows_in = mode ? RS_FIRST : RS_BODY;
               RS_FLUSH: rows_in = RS_FIRST;
               default:  rows_in = RS_FIRST;
            endcase
         end else begin
            col_in  = c + ADDR_W'(1);
            rows_in = mode ? RS_FLUSH : rows_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= RS_FIRST;
      end else begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   assign op_valid            = take && active;
   assign op_col              = c;
   assign op_bottom           = mode ? '0 : sample;
   assign op_flags.last       = last;
   assign op_flags.frame_end  = last && (mode || (rows_ff == RS_FLUSH));
   assign op_flags.emit       = mode || (rows_ff == RS_BODY);
   assign op_flags.zero_top   = (rows_ff == RS_FIRST);
   assign op_flags.has_left   = (c != '0);
   assign op_flags.has_right  = !last;

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      op_valid && op_flags.frame_end |=> rows_ff == RS_FIRST && col_ff == '0)
      else $error("frame end did not restart the sequencer");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      op_valid && op_flags.last |=> col_ff == '0)
      else $error("column did not wrap after last column");

   a_flush_holds: assert property (@(posedge clock) disable iff (reset)
      take && !mode && rows_ff == RS_FLUSH |=> $stable(col_ff) && rows_ff == RS_FLUSH)
      else $error("element during flush changed state");

endmodule

`default_nettype wire

@@ rtl/core/fnss_lines.sv @@
`default_nettype none

module fnss_lines import fnss_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         op_valid,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] op_col,
   input  wire logic [SAMPLE_BITS-1:0]       op_bottom,
   input  wire fnss_flags_type               op_flags,
   output logic                              in_ready,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [SAMPLE_BITS+1:0]            out_sum,
   output logic                              out_row_end,
   output logic                              out_frame_end
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int SUM_W  = SAMPLE_BITS + 2;

   logic                   s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]      s1_col_ff;
   logic [SAMPLE_BITS-1:0] s1_bottom_ff;
   fnss_flags_type         s1_flags_ff;

   logic                   fwd_valid_ff;
   logic [ADDR_W-1:0]      fwd_col_ff;
   logic [SAMPLE_BITS-1:0] fwd_rbp_ff;
   logic [SAMPLE_BITS-1:0] fwd_prev_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]       out_sum_ff;
   logic                   out_row_end_ff;
   logic                   out_frame_end_ff;

   logic [SAMPLE_BITS-1:0] rbp_c_q, rbp_l_q, prev_c_q, prev_r_q;
   logic [SAMPLE_BITS-1:0] top, left, prev_c, right;
   logic [SAMPLE_BITS-1:0] rbp_wdata;
   logic [ADDR_W-1:0]      col_m1, col_p1;
   logic                   s1_adv;
   logic                   load;
   logic signed [SUM_W-1:0] sum;

   assign s1_adv   = s1_valid_ff && (!s1_flags_ff.emit || !out_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || s1_adv;
   assign load     = s1_adv && s1_flags_ff.emit;

   fnss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_rbp_c (
      .clock(clock), .wr_en(s1_adv), .wr_addr(s1_col_ff), .wr_data(rbp_wdata),
      .rd_en(op_valid), .rd_addr(op_col), .rd_data(rbp_c_q)
   );

   fnss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_rbp_l (
      .clock(clock), .wr_en(s1_adv), .wr_addr(s1_col_ff), .wr_data(rbp_wdata),
      .rd_en(op_valid), .rd_addr(op_col - ADDR_W'(1)), .rd_data(rbp_l_q)
   );

   fnss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_prev_c (
      .clock(clock), .wr_en(s1_adv), .wr_addr(s1_col_ff), .wr_data(s1_bottom_ff),
      .rd_en(op_valid), .rd_addr(op_col), .rd_data(prev_c_q)
   );

   fnss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_prev_r (
      .clock(clock), .wr_en(s1_adv), .wr_addr(s1_col_ff), .wr_data(s1_bottom_ff),
      .rd_en(op_valid), .rd_addr(op_col + ADDR_W'(1)), .rd_data(prev_r_q)
   );

   always_comb begin
      col_m1    = s1_col_ff - ADDR_W'(1);
      col_p1    = s1_col_ff + ADDR_W'(1);
      top       = (fwd_valid_ff && fwd_col_ff == s1_col_ff) ? fwd_rbp_ff  : rbp_c_q;
      left      = (fwd_valid_ff && fwd_col_ff == col_m1)    ? fwd_rbp_ff  : rbp_l_q;
      prev_c    = (fwd_valid_ff && fwd_col_ff == s1_col_ff) ? fwd_prev_ff : prev_c_q;
      right     = (fwd_valid_ff && fwd_col_ff == col_p1)    ? fwd_prev_ff : prev_r_q;
      rbp_wdata = s1_flags_ff.zero_top ? '0 : prev_c;
      if (!s1_flags_ff.has_left) begin
         left = '0;
      end
      if (!s1_flags_ff.has_right) begin
         right = '0;
      end
      sum = $signed({{2{left[SAMPLE_BITS-1]}}, left})
          + $signed({{2{top[SAMPLE_BITS-1]}}, top})
          + $signed({{2{right[SAMPLE_BITS-1]}}, right})
          + $signed({{2{s1_bottom_ff[SAMPLE_BITS-1]}}, s1_bottom_ff});
   end

   always_comb begin
      s1_valid_in = op_valid ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (op_valid) begin
            fwd_valid_ff <= s1_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_valid) begin
         s1_col_ff    <= op_col;
         s1_bottom_ff <= op_bottom;
         s1_flags_ff  <= op_flags;
         fwd_col_ff   <= s1_col_ff;
         fwd_rbp_ff   <= rbp_wdata;
         fwd_prev_ff  <= s1_bottom_ff;
      end
      if (load) begin
         out_sum_ff       <= sum;
         out_row_end_ff   <= s1_flags_ff.last;
         out_frame_end_ff <= s1_flags_ff.frame_end;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_sum       = out_sum_ff;
   assign out_row_end   = out_row_end_ff;
   assign out_frame_end = out_frame_end_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_col_ff) && $stable(rbp_c_q))
      else $error("stalled stage lost its operands");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_adv && s1_flags_ff.emit))
      else $error("result appeared without a stage advance");

   a_no_entry_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !op_valid)
      else $error("item entered a stalled stage");

endmodule

`default_nettype wire

@@ rtl/core/four_neighbor_sum_stencil.sv @@
`default_nettype none

// Four-neighbour cross stencil over a raster-ordered matrix, zero padded at every edge.
// One item is taken per clock unless the output stalls; results pass the operand and
// output registers. Each result belongs to the row above the element that releases it,
// so output trails input by one row; after the last row send row_width flush items
// (mode = 1) to drain it. The two line stores live in synchronous RAMs of
// MAX_WIDTH entries, each kept as two copies so that three addresses can be read per item;
// the read-modify-write loop closes through one forwarding register. The stores are not
// cleared after reset: the first row of each matrix writes zeros into the upper store.
// row_width sits at byte address 0 and may only be changed while the block is idle.
module four_neighbor_sum_stencil import fnss_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_mode,
   input  wire logic [SAMPLE_BITS-1:0]     req_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [SAMPLE_BITS+1:0]          rsp_neighbor_sum,
   output logic                            rsp_row_end,
   output logic                            rsp_frame_end,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [CSR_DATA_BITS-1:0]   pwdata,
   output logic [CSR_DATA_BITS-1:0]        prdata,
   output logic                            pready
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   logic [ROW_WIDTH_BITS-1:0] row_width_ff;
   logic                      take;
   logic                      op_valid;
   logic [ADDR_W-1:0]         op_col;
   logic [SAMPLE_BITS-1:0]    op_bottom;
   fnss_flags_type            op_flags;

   assign pready = 1'b1;
   assign take   = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_WIDTH) begin
         row_width_ff <= pwdata[ROW_WIDTH_BITS-1:0];
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ROW_WIDTH: prdata = CSR_DATA_BITS'(row_width_ff);
         default:       prdata = '0;
      endcase
   end

   fnss_seq #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_seq (
      .clock(clock),
      .reset(reset),
      .row_width(row_width_ff),
      .take(take),
      .mode(req_mode),
      .sample(req_sample),
      .op_valid(op_valid),
      .op_col(op_col),
      .op_bottom(op_bottom),
      .op_flags(op_flags)
   );

   fnss_lines #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lines (
      .clock(clock),
      .reset(reset),
      .op_valid(op_valid),
      .op_col(op_col),
      .op_bottom(op_bottom),
      .op_flags(op_flags),
      .in_ready(req_ready),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_sum(rsp_neighbor_sum),
      .out_row_end(rsp_row_end),
      .out_frame_end(rsp_frame_end)
   );

endmodule

`default_nettype wire
